// ===== design/bplru_pkg.sv =====
package bplru_pkg;

  localparam int PAGES_PER_BLOCK = 64;
  localparam int MAX_BLOCKS      = 64;

  localparam int LPN_W   = 32;
  localparam int OFF_W   = $clog2(PAGES_PER_BLOCK);
  localparam int BLK_W   = LPN_W - OFF_W;
  localparam int SLOT_W  = $clog2(MAX_BLOCKS);
  localparam int VCNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int PCNT_W  = $clog2(PAGES_PER_BLOCK + 1);
  localparam int HELD_W  = 13;
  localparam int THR_W   = 7;
  localparam int CFG_W   = 13;
  localparam int CFG_A_W = 2;
  localparam int OUT_W   = 96;

  localparam logic [CFG_A_W-1:0] CFG_MAX_PAGES = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_SEQ_THR   = 2'd1;

  localparam logic [THR_W-1:0] SAME_CNT_MAX = 7'd64;

  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_SCAN,
    CMD_DECIDE,
    CMD_UPDATE,
    CMD_FINISH
  } cmd_op_t;

  typedef enum logic [2:0] {
    RK_NONE,
    RK_MRU,
    RK_LRU,
    RK_INS_MRU,
    RK_INS_LRU
  } rank_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    cmd_op_t           op;
    logic              rd;
    logic              proc;
    logic [SLOT_W-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [BLK_W-1:0]           tag;
    logic [PAGES_PER_BLOCK-1:0] pres;
    logic [PCNT_W-1:0]          cnt;
    logic [SLOT_W-1:0]          rank;
  } entry_t;

endpackage

// ===== design/bplru_ctrl.sv =====
module bplru_ctrl
  import bplru_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t            state_r, state_nxt;
  logic [VCNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd.op    = CMD_IDLE;
    cmd.rd    = 1'b0;
    cmd.proc  = 1'b0;
    cmd.addr  = cnt_r[SLOT_W-1:0];
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = CMD_LOAD;
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN, ST_UPDATE: begin
        cmd.op   = (state_r == ST_SCAN) ? CMD_SCAN : CMD_UPDATE;
        cmd.rd   = cnt_r < VCNT_W'(MAX_BLOCKS);
        cmd.proc = cnt_r != '0;
        if (cnt_r == VCNT_W'(MAX_BLOCKS)) begin
          cnt_nxt   = '0;
          state_nxt = (state_r == ST_SCAN) ? ST_DECIDE : ST_FINISH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DECIDE: begin
        cmd.op    = CMD_DECIDE;
        state_nxt = st.is_read ? ST_FINISH : ST_UPDATE;
      end
      ST_FINISH: begin
        cmd.op = CMD_FINISH;
        if (st.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= VCNT_W'(MAX_BLOCKS))
    else $error("slot counter out of range");

  a_scan_to_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && cnt_r == VCNT_W'(MAX_BLOCKS)) |=> state_r == ST_DECIDE)
    else $error("scan did not end in decide");

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_SCAN && cnt_r == '0))
    else $error("accepted word did not start a scan");

endmodule

// ===== design/bplru_dp.sv =====
module bplru_dp
  import bplru_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  logic [LPN_W-1:0]   in_lpn,
  input  logic               in_is_read,
  input  cmd_t               cmd,
  output status_t            st,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_W-1:0]   out_tdata
);

  logic [HELD_W-1:0] max_pages_r;
  logic [THR_W-1:0]  seq_thr_r;

  logic [BLK_W-1:0]  blk_r;
  logic [OFF_W-1:0]  off_r;
  logic              rd_r;
  logic [BLK_W-1:0]  last_blk_r;
  logic              last_vld_r;
  logic [THR_W-1:0]  same_cnt_r;
  logic              seq_r;

  entry_t            mem [MAX_BLOCKS];
  entry_t            rdata_r;
  logic [SLOT_W-1:0] paddr_r;
  logic [MAX_BLOCKS-1:0] valid_r;
  logic [VCNT_W-1:0] vcnt_r;
  logic [HELD_W-1:0] held_r;

  // scan results
  logic              s_ok_r, lru_ok_r, lru2_ok_r, free_ok_r;
  logic [SLOT_W-1:0] s_slot_r, lru_slot_r, lru2_slot_r, free_slot_r;
  entry_t            s_ent_r, lru_ent_r, lru2_ent_r;

  // decision
  rank_op_t          op_r;
  logic [SLOT_W-1:0] t_slot_r, t_rank_r, tgt_r, v_slot_r, v_rank_r;
  logic              ev_r, ins_r, addp_r;
  logic [OUT_W-1:0]  res_r;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;

  logic [PAGES_PER_BLOCK-1:0] bit_w;
  assign bit_w = PAGES_PER_BLOCK'(1) << off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pages_r <= HELD_W'(1024);
      seq_thr_r   <= THR_W'(32);
    end else if (cfg_we) begin
      if (cfg_addr == CFG_MAX_PAGES) max_pages_r <= cfg_wdata[HELD_W-1:0];
      else if (cfg_addr == CFG_SEQ_THR) seq_thr_r <= cfg_wdata[THR_W-1:0];
    end
  end

  // same-block tracking on accept
  logic [BLK_W-1:0] in_blk;
  logic [BLK_W-1:0] lb;
  logic [THR_W-1:0] same_nxt;
  logic             same;
  always_comb begin
    in_blk   = in_lpn[LPN_W-1:OFF_W];
    lb       = last_vld_r ? last_blk_r : in_blk;
    same     = lb == in_blk;
    same_nxt = same ? ((same_cnt_r < SAME_CNT_MAX) ? same_cnt_r + 1'b1 : same_cnt_r)
                    : THR_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_blk_r <= '0;
      last_vld_r <= 1'b0;
      same_cnt_r <= '0;
      seq_r      <= 1'b0;
    end else if (cmd.op == CMD_LOAD) begin
      last_blk_r <= in_blk;
      last_vld_r <= 1'b1;
      same_cnt_r <= same_nxt;
      seq_r      <= same && (same_nxt >= seq_thr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_LOAD) begin
      blk_r <= in_blk;
      off_r <= in_lpn[OFF_W-1:0];
      rd_r  <= in_is_read;
    end
  end

  // memory read port
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata_r <= mem[cmd.addr];
      paddr_r <= cmd.addr;
    end
  end

  // scan pass
  logic [SLOT_W-1:0] nm1, nm2;
  logic              pvalid;
  assign nm1    = SLOT_W'(vcnt_r - 1'b1);
  assign nm2    = SLOT_W'(vcnt_r - 2'd2);
  assign pvalid = valid_r[paddr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_ok_r    <= 1'b0;
      lru_ok_r  <= 1'b0;
      lru2_ok_r <= 1'b0;
      free_ok_r <= 1'b0;
    end else if (cmd.op == CMD_LOAD) begin
      s_ok_r    <= 1'b0;
      lru_ok_r  <= 1'b0;
      lru2_ok_r <= 1'b0;
      free_ok_r <= 1'b0;
    end else if (cmd.op == CMD_SCAN && cmd.proc) begin
      if (pvalid) begin
        if (rdata_r.tag == blk_r) s_ok_r <= 1'b1;
        if (vcnt_r >= VCNT_W'(1) && rdata_r.rank == nm1) lru_ok_r <= 1'b1;
        if (vcnt_r >= VCNT_W'(2) && rdata_r.rank == nm2) lru2_ok_r <= 1'b1;
      end else begin
        free_ok_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_SCAN && cmd.proc) begin
      if (pvalid) begin
        if (rdata_r.tag == blk_r) begin
          s_slot_r <= paddr_r;
          s_ent_r  <= rdata_r;
        end
        if (rdata_r.rank == nm1) begin
          lru_slot_r <= paddr_r;
          lru_ent_r  <= rdata_r;
        end
        if (rdata_r.rank == nm2) begin
          lru2_slot_r <= paddr_r;
          lru2_ent_r  <= rdata_r;
        end
      end else if (!free_ok_r) begin
        free_slot_r <= paddr_r;
      end
    end
  end

  // decision
  logic              hit, need, v_ok, f_ok, add;
  logic [SLOT_W-1:0] v_slot, f_slot;
  entry_t            v_ent;
  logic [VCNT_W-1:0] n1;
  logic [SLOT_W-1:0] s_adj;
  rank_op_t          op_c;
  logic [SLOT_W-1:0] t_slot_c, t_rank_c, tgt_c;
  logic              ins_c, addp_c;
  logic [HELD_W-1:0] held_c;
  logic [VCNT_W-1:0] vcnt_c;

  always_comb begin
    hit    = s_ok_r && s_ent_r.pres[off_r];
    need   = (held_r >= max_pages_r) || (!s_ok_r && vcnt_r >= VCNT_W'(MAX_BLOCKS));
    v_ok   = 1'b0;
    v_slot = lru_slot_r;
    v_ent  = lru_ent_r;
    if (!rd_r && !hit && need && vcnt_r != '0 && lru_ok_r) begin
      if (lru_ent_r.tag == blk_r) begin
        v_ok   = lru2_ok_r;
        v_slot = lru2_slot_r;
        v_ent  = lru2_ent_r;
      end else begin
        v_ok = 1'b1;
      end
    end
    n1     = vcnt_r - VCNT_W'(v_ok);
    s_adj  = (v_ok && s_ent_r.rank > v_ent.rank) ? s_ent_r.rank - 1'b1 : s_ent_r.rank;
    f_slot = (free_ok_r && !(v_ok && v_slot < free_slot_r)) ? free_slot_r : v_slot;
    f_ok   = !s_ok_r && (free_ok_r || v_ok);

    op_c     = RK_NONE;
    t_slot_c = s_slot_r;
    t_rank_c = s_adj;
    tgt_c    = '0;
    ins_c    = 1'b0;
    addp_c   = 1'b0;
    add      = 1'b0;
    if (!rd_r) begin
      if (hit) begin
        op_c     = seq_r ? RK_LRU : RK_MRU;
        t_rank_c = s_ent_r.rank;
        tgt_c    = seq_r ? SLOT_W'(vcnt_r - 1'b1) : '0;
      end else if (s_ok_r) begin
        op_c   = seq_r ? RK_LRU : RK_MRU;
        tgt_c  = seq_r ? SLOT_W'(n1 - 1'b1) : '0;
        addp_c = 1'b1;
        add    = 1'b1;
      end else if (f_ok) begin
        op_c     = seq_r ? RK_INS_LRU : RK_INS_MRU;
        t_slot_c = f_slot;
        tgt_c    = seq_r ? SLOT_W'(n1) : '0;
        ins_c    = 1'b1;
        add      = 1'b1;
      end
    end
    held_c = held_r - (v_ok ? HELD_W'(v_ent.cnt) : '0) + HELD_W'(add);
    vcnt_c = n1 + VCNT_W'(ins_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      vcnt_r <= '0;
      op_r   <= RK_NONE;
      ev_r   <= 1'b0;
      ins_r  <= 1'b0;
      addp_r <= 1'b0;
    end else if (cmd.op == CMD_DECIDE) begin
      held_r <= held_c;
      vcnt_r <= vcnt_c;
      op_r   <= op_c;
      ev_r   <= v_ok;
      ins_r  <= ins_c;
      addp_r <= addp_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_DECIDE) begin
      t_slot_r <= t_slot_c;
      t_rank_r <= t_rank_c;
      tgt_r    <= tgt_c;
      v_slot_r <= v_slot;
      v_rank_r <= v_ent.rank;
      // pad, victim, evict, flash_read, seq_mode, hit
      res_r <= {2'b00,
                v_ok ? ~v_ent.pres : {PAGES_PER_BLOCK{1'b0}},
                v_ok ? v_ent.tag : {BLK_W{1'b0}},
                v_ok, !hit, seq_r, hit};
    end
  end

  // update pass: rewrite ranks, insert, evict
  logic [SLOT_W-1:0] r1, rn;
  logic              is_t, upd_wr;
  entry_t            wr_ent;
  always_comb begin
    r1 = (ev_r && rdata_r.rank > v_rank_r) ? rdata_r.rank - 1'b1 : rdata_r.rank;
    unique case (op_r)
      RK_MRU:     rn = (r1 < t_rank_r) ? r1 + 1'b1 : r1;
      RK_LRU:     rn = (r1 > t_rank_r) ? r1 - 1'b1 : r1;
      RK_INS_MRU: rn = r1 + 1'b1;
      default:    rn = r1;
    endcase
    is_t   = (paddr_r == t_slot_r) && (op_r != RK_NONE);
    wr_ent = rdata_r;
    wr_ent.rank = is_t ? tgt_r : rn;
    if (ins_r && is_t) begin
      wr_ent.tag  = blk_r;
      wr_ent.pres = bit_w;
      wr_ent.cnt  = PCNT_W'(1);
    end else if (addp_r && is_t) begin
      wr_ent.pres = rdata_r.pres | bit_w;
      wr_ent.cnt  = rdata_r.cnt + 1'b1;
    end
    upd_wr = (cmd.op == CMD_UPDATE) && cmd.proc && (pvalid || (ins_r && is_t));
  end

  always_ff @(posedge clk) begin
    if (upd_wr) mem[paddr_r] <= wr_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.op == CMD_UPDATE && cmd.proc) begin
      if (ins_r && is_t) valid_r[paddr_r] <= 1'b1;
      else if (ev_r && paddr_r == v_slot_r) valid_r[paddr_r] <= 1'b0;
    end
  end

  // output register
  logic load;
  assign load        = (cmd.op == CMD_FINISH) && (!out_valid_r || out_tready);
  assign st.out_free = !out_valid_r || out_tready;
  assign st.is_read  = rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (load) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) out_data_r <= res_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_victim_not_req: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == CMD_DECIDE && v_ok) |-> v_ent.tag != blk_r)
    else $error("evicted the requested block");

  a_no_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r[3]) |-> out_data_r[93:4] == '0)
    else $error("victim fields set without eviction");

  a_vcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    vcnt_r <= VCNT_W'(MAX_BLOCKS))
    else $error("block count above slot count");

endmodule

// ===== design/block_padding_lru_write_buffer.sv =====
// Block-grouped LRU write buffer for flash pages. Each input word carries a
// logical page number (in_tdata) and a read flag (in_tuser); one result word
// follows for each. A request takes one pass over all 64 block slots of the
// entry memory to match tags and locate the LRU victims, and writes take a
// second read-modify-write pass to rerank, insert and evict, since the slot
// memory has a single read and a single write port. A finished result waits in
// the output register while the next request is accepted and scanned.
module block_padding_lru_write_buffer
  import bplru_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [LPN_W-1:0]   in_tdata,  // lpn
  input  logic               in_tuser,  // is_read
  output logic               out_tvalid,
  input  logic               out_tready,
  // hit, seq_mode, flash_read, evict, victim_block[25:0], pad_read_mask[63:0]
  output logic [OUT_W-1:0]   out_tdata
);

  cmd_t    cmd;
  status_t st;

  bplru_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  bplru_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_lpn     (in_tdata),
    .in_is_read (in_tuser),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
